>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL of the top-k sort unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked on every rising edge outside reset.
`define TKS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("top-k sort check failed");
// Condition that must never be true outside reset.
`define TKS_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("top-k sort forbidden condition");
`else
`define TKS_ASSERT(lbl, clk, rst, prop)
`define TKS_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> hdl/tks_pkg.sv
// Package of the top-k sort unit: widths, payload structs, state enum.
// No dependencies; used by tks_cell and top_k_descending_sort_unit.
package tks_pkg;

   localparam int ScoreW = 14;
   localparam int TagW   = 6;
   localparam int RankW  = 4;
   localparam int TopKDefault = 10;

   typedef struct packed {
      logic [ScoreW-1:0] score;
      logic [TagW-1:0]   tag;
      logic              batch_end;
   } req_type;

   typedef struct packed {
      logic [RankW-1:0]  rank;
      logic [TagW-1:0]   out_tag;
      logic [ScoreW-1:0] out_score;
      logic              run_last;
   } rsp_type;

   // one kept entry as held by a cell
   typedef struct packed {
      logic              valid;
      logic [ScoreW-1:0] score;
      logic [TagW-1:0]   tag;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic load;   // insert the broadcast request
      logic shift;  // move every entry one place toward rank 0
   } ctrl_type;

   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

>>> hdl/top_k_descending_sort_unit.sv
// Top level of the top-k sort unit: chain of tks_cell plus load/drain control.
// Depends on tks_pkg, tks_cell and assert_macros.svh.
//
// Usage:
//   Requests (score, tag, batch_end) enter on req_valid/req_ready. Each
//   accepted request is inserted into a row of TOP_K cells kept sorted by
//   descending score; equal scores keep their load order and the lowest
//   entry drops out when the row is full.
//   A request with batch_end set is inserted, and then the row drains: one
//   result per cycle on rsp_valid/rsp_ready while rsp_ready is high, rank 0
//   first, run_last on the final one. The first result is valid the cycle
//   after the batch_end request is accepted.
//   Throughput: one request per cycle while loading. Draining delivers each
//   kept entry (at most TOP_K) in turn, the row shifting one place toward
//   rank 0 per delivered result; req_ready is low during the drain.
//   A stalled receiver holds the row and the current result unchanged.
//   Reset clears all cell valid bits and returns to loading; the row is
//   empty again after every drain.
`include "assert_macros.svh"

module top_k_descending_sort_unit #(
   parameter int TOP_K = tks_pkg::TopKDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tks_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tks_pkg::rsp_type rsp_data
);

   tks_pkg::state_type state_ff, state_in;
   logic [tks_pkg::RankW-1:0] rank_ff, rank_in;
   tks_pkg::ctrl_type ctrl;
   tks_pkg::entry_type entries [TOP_K];
   logic [TOP_K-1:0] ins_vec;
   logic [TOP_K-1:0] valid_vec;
   logic rsp_take, run_last;
   tks_pkg::entry_type empty_entry, new_entry;

   assign rsp_take    = rsp_valid && rsp_ready;
   assign empty_entry = '{valid: 1'b0, score: '0, tag: '0};
   assign new_entry   = '{valid: 1'b1, score: req_data.score, tag: req_data.tag};

   // cell row
   for (genvar i = 0; i < TOP_K; i++) begin : g_cell
      tks_pkg::entry_type prev_e, next_e;
      logic prev_i;
      if (i == 0) begin : g_first
         assign prev_e = new_entry;
         assign prev_i = 1'b0;
      end else begin : g_mid
         assign prev_e = entries[i-1];
         assign prev_i = ins_vec[i-1];
      end
      if (i == TOP_K-1) begin : g_last
         assign next_e = empty_entry;
      end else begin : g_nxt
         assign next_e = entries[i+1];
      end
      tks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_score  (req_data.score),
         .new_tag    (req_data.tag),
         .prev_entry (prev_e),
         .prev_ins   (prev_i),
         .next_entry (next_e),
         .ins        (ins_vec[i]),
         .entry      (entries[i])
      );
      assign valid_vec[i] = entries[i].valid;
   end

   // final result when the entry behind rank 0 is empty
   if (TOP_K == 1) begin : g_one
      assign run_last = 1'b1;
   end else begin : g_many
      assign run_last = !entries[1].valid;
   end

   // outputs straight from the head cell and the rank register
   assign rsp_data = '{rank: rank_ff, out_tag: entries[0].tag,
                       out_score: entries[0].score, run_last: run_last};

   // next state and control; ready is constant within each state
   always_comb begin
      state_in   = state_ff;
      rank_in    = rank_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.shift = 1'b0;
      case (state_ff)
         tks_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
            if (req_valid && req_data.batch_end) begin
               state_in = tks_pkg::ST_DRAIN;
               rank_in  = '0;
            end
         end
         tks_pkg::ST_DRAIN: begin
            rsp_valid  = 1'b1;
            ctrl.shift = rsp_ready;
            if (rsp_ready) begin
               rank_in = rank_ff + tks_pkg::RankW'(1);
               if (run_last) begin
                  state_in = tks_pkg::ST_LOAD;
               end
            end
         end
         default: begin
            state_in = tks_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tks_pkg::ST_LOAD;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rank_ff  <= rank_in;
      end
   end

   // checks
   `TKS_ASSERT(a_head_valid, clock, reset, rsp_valid |-> entries[0].valid)
   `TKS_ASSERT(a_prefix, clock, reset, (valid_vec & (valid_vec + TOP_K'(1))) == '0)
   `TKS_ASSERT(a_rank_step, clock, reset, (rsp_take && !run_last) |=> (rsp_valid && (rsp_data.rank == $past(rank_ff) + tks_pkg::RankW'(1))))
   `TKS_NEVER(a_no_overlap, clock, reset, req_ready && rsp_valid)

endmodule

>>> hdl/tks_cell.sv
// One cell of the insertion chain: holds one kept entry of the sorted list.
// Depends on tks_pkg.
module tks_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  tks_pkg::ctrl_type        ctrl,
   input  logic [tks_pkg::ScoreW-1:0] new_score,
   input  logic [tks_pkg::TagW-1:0] new_tag,
   input  tks_pkg::entry_type       prev_entry,
   input  logic                     prev_ins,
   input  tks_pkg::entry_type       next_entry,
   output logic                     ins,
   output tks_pkg::entry_type       entry
);

   logic                       valid_ff, valid_in;
   logic [tks_pkg::ScoreW-1:0] score_ff, score_in;
   logic [tks_pkg::TagW-1:0]   tag_ff, tag_in;

   // new request ranks ahead of this entry; equal scores stay ahead
   assign ins = !valid_ff || (new_score > score_ff);

   assign entry = '{valid: valid_ff, score: score_ff, tag: tag_ff};

   // next entry: take the neighbor's, the new request, or hold
   always_comb begin
      valid_in = valid_ff;
      score_in = score_ff;
      tag_in   = tag_ff;
      if (ctrl.shift) begin
         valid_in = next_entry.valid;
         score_in = next_entry.score;
         tag_in   = next_entry.tag;
      end else if (ctrl.load && ins) begin
         if (prev_ins) begin
            valid_in = prev_entry.valid;
            score_in = prev_entry.score;
            tag_in   = prev_entry.tag;
         end else begin
            valid_in = 1'b1;
            score_in = new_score;
            tag_in   = new_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      score_ff <= score_in;
      tag_ff   <= tag_in;
   end

endmodule
